### src/htbd_pkg.sv
package htbd_pkg;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_BUILD  = 2'd1;
   localparam logic [1:0] OP_DECODE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] KIND_BUILT  = 2'd0;
   localparam logic [1:0] KIND_SYMBOL = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_EMPTY  = 2'd1;
   localparam logic [1:0] ERR_NOTREE = 2'd2;

   localparam int NODE_WEIGHT_W = 32;
   localparam int SYM_OUT_W     = 8;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_LRD   = 11'b000_0000_0010,
      ST_LWR   = 11'b000_0000_0100,
      ST_SCAN  = 11'b000_0000_1000,
      ST_KILLA = 11'b000_0001_0000,
      ST_KILLB = 11'b000_0010_0000,
      ST_MERGE = 11'b000_0100_0000,
      ST_DRD   = 11'b000_1000_0000,
      ST_DNXT  = 11'b001_0000_0000,
      ST_DCHK  = 11'b010_0000_0000,
      ST_OUT   = 11'b100_0000_0000
   } state_type;

endpackage

### src/htbd_if.sv
interface htbd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  symbol;
   logic [23:0] weight;
   logic        code_bit;

   modport source (output valid, opcode, symbol, weight, code_bit, input ready);
   modport sink   (input valid, opcode, symbol, weight, code_bit, output ready);
endinterface

interface htbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] decoded_symbol;
   logic [1:0] error_code;

   modport source (output valid, result_kind, decoded_symbol, error_code, input ready);
   modport sink   (input valid, result_kind, decoded_symbol, error_code, output ready);
endinterface

### src/htbd_ram.sv
module htbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/huffman_tree_build_and_decode_core.sv
// Load and clear finish in idle. A decode bit goes to the output stage on error or a
// single-leaf tree, else through DRD, DNXT and DCHK, and on to it only at a leaf.
// A build visits every symbol slot and writes a leaf for each loaded symbol, then per
// merge one node-store read port scans every node once.
// Throughput: one word at a time; req ready only while the sequencer is idle.
// Reset (synchronous, active high) clears the symbol table, the tree and the output.
module huffman_tree_build_and_decode_core
   import htbd_pkg::*;
#(
   parameter int SYMBOL_COUNT = 256,
   parameter int WEIGHT_BITS  = 24
) (
   input  logic       clock,
   input  logic       reset,
   htbd_req_if.sink   req_if,
   htbd_rsp_if.source rsp_if
);

   localparam int NODE_DEPTH = 2 * SYMBOL_COUNT - 1;
   localparam int NI     = $clog2(NODE_DEPTH);
   localparam int CNT_W  = $clog2(NODE_DEPTH + 1);
   localparam int SYM_W  = $clog2(SYMBOL_COUNT);
   localparam int SCNT_W = $clog2(SYMBOL_COUNT + 1);
   localparam int LEAF_W = (WEIGHT_BITS < 24) ? WEIGHT_BITS : 24;
   // node word: {live, weight, left, right, symbol}
   localparam int SYM_OFF   = 0;
   localparam int RIGHT_OFF = SYM_OUT_W;
   localparam int LEFT_OFF  = RIGHT_OFF + NI;
   localparam int W_OFF     = LEFT_OFF + NI;
   localparam int LIVE_OFF  = W_OFF + NODE_WEIGHT_W;
   localparam int NW        = LIVE_OFF + 1;

   state_type state_ff, state_in;

   logic [SYMBOL_COUNT-1:0] present_ff, present_in;
   logic [CNT_W-1:0]  total_ff, total_in, live_ff, live_in, scan_ff, scan_in;
   logic [SCNT_W-1:0] sidx_ff, sidx_in;
   logic              sv_ff, sv_in, f1_ff, f1_in, f2_ff, f2_in;
   logic [NI-1:0]     idx_d_ff, idx_d_in, i1_ff, i1_in, i2_ff, i2_in;
   logic [NW-1:0]     b1_ff, b1_in, b2_ff, b2_in;
   logic [NI-1:0]     root_ff, root_in, walk_ff, walk_in, nxt_ff, nxt_in;
   logic              tree_ok_ff, tree_ok_in, root_leaf_ff, root_leaf_in;
   logic [7:0]        root_sym_ff, root_sym_in;
   logic              bit_ff, bit_in;
   logic [1:0]        res_kind_ff, res_kind_in, res_err_ff, res_err_in;
   logic [7:0]        res_sym_ff, res_sym_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in, rsp_err_ff, rsp_err_in;
   logic [7:0]        rsp_sym_ff, rsp_sym_in;

   // leaf weight store
   logic              leaf_wr_en;
   logic [LEAF_W-1:0] leaf_rd;

   // node store
   logic          node_wr_en;
   logic [NI-1:0] node_wr_addr, node_rd_addr;
   logic [NW-1:0] node_wr_data, node_rd;

   logic          accept;
   logic          in_range;
   logic [NODE_WEIGHT_W:0] sum;
   logic [NODE_WEIGHT_W-1:0] cur_w, w1, w2;
   logic [NI-1:0] next_node;
   logic          out_free;

   assign accept   = req_if.valid && req_if.ready;
   assign in_range = {1'b0, req_if.symbol} < 9'(SYMBOL_COUNT);
   assign leaf_wr_en = accept && req_if.opcode == OP_LOAD && in_range;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   assign cur_w = node_rd[W_OFF +: NODE_WEIGHT_W];
   assign w1    = b1_ff[W_OFF +: NODE_WEIGHT_W];
   assign w2    = b2_ff[W_OFF +: NODE_WEIGHT_W];
   assign sum   = {1'b0, w1} + {1'b0, w2};
   assign next_node = bit_ff ? node_rd[RIGHT_OFF +: NI] : node_rd[LEFT_OFF +: NI];

   htbd_ram #(.WIDTH(LEAF_W), .DEPTH(SYMBOL_COUNT)) u_leaf_ram (
      .clock   (clock),
      .wr_en   (leaf_wr_en),
      .wr_addr (req_if.symbol[SYM_W-1:0]),
      .wr_data (req_if.weight[LEAF_W-1:0]),
      .rd_addr (sidx_ff[SYM_W-1:0]),
      .rd_data (leaf_rd)
   );

   htbd_ram #(.WIDTH(NW), .DEPTH(NODE_DEPTH)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd)
   );

   // node store read address: scan walks the nodes, decode follows the walk
   always_comb begin
      unique case (state_ff)
         ST_DRD:  node_rd_addr = walk_ff;
         ST_DNXT: node_rd_addr = next_node;
         default: node_rd_addr = scan_ff[NI-1:0];
      endcase
   end

   // node store writes: new leaf, retire the two minima, new internal node
   always_comb begin
      node_wr_en   = 1'b0;
      node_wr_addr = total_ff[NI-1:0];
      node_wr_data = b1_ff;
      unique case (state_ff)
         ST_LWR: begin
            node_wr_en   = present_ff[sidx_ff[SYM_W-1:0]];
            node_wr_data = {1'b1, NODE_WEIGHT_W'(leaf_rd), total_ff[NI-1:0],
                            total_ff[NI-1:0], 8'(sidx_ff)};
         end
         ST_KILLA: begin
            node_wr_en   = 1'b1;
            node_wr_addr = i1_ff;
            node_wr_data = {1'b0, b1_ff[LIVE_OFF-1:0]};
         end
         ST_KILLB: begin
            node_wr_en   = 1'b1;
            node_wr_addr = i2_ff;
            node_wr_data = {1'b0, b2_ff[LIVE_OFF-1:0]};
         end
         ST_MERGE: begin
            node_wr_en   = 1'b1;
            node_wr_data = {1'b1,
                            sum[NODE_WEIGHT_W] ? {NODE_WEIGHT_W{1'b1}} : sum[NODE_WEIGHT_W-1:0],
                            i1_ff, i2_ff, 8'd0};
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      present_in   = present_ff;
      total_in     = total_ff;
      live_in      = live_ff;
      scan_in      = scan_ff;
      sidx_in      = sidx_ff;
      sv_in        = 1'b0;
      f1_in        = f1_ff;
      f2_in        = f2_ff;
      idx_d_in     = scan_ff[NI-1:0];
      i1_in        = i1_ff;
      i2_in        = i2_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      root_in      = root_ff;
      walk_in      = walk_ff;
      nxt_in       = nxt_ff;
      tree_ok_in   = tree_ok_ff;
      root_leaf_in = root_leaf_ff;
      root_sym_in  = root_sym_ff;
      bit_in       = bit_ff;
      res_kind_in  = res_kind_ff;
      res_sym_in   = res_sym_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_if.opcode)
                  OP_LOAD: begin
                     if (in_range) begin
                        present_in[req_if.symbol[SYM_W-1:0]] = 1'b1;
                     end
                  end
                  OP_BUILD: begin
                     total_in = '0;
                     sidx_in  = '0;
                     state_in = ST_LRD;
                  end
                  OP_DECODE: begin
                     bit_in = req_if.code_bit;
                     if (!tree_ok_ff) begin
                        res_kind_in = KIND_ERROR;
                        res_sym_in  = '0;
                        res_err_in  = ERR_NOTREE;
                        state_in    = ST_OUT;
                     end else if (root_leaf_ff) begin
                        walk_in     = root_ff;
                        res_kind_in = KIND_SYMBOL;
                        res_sym_in  = root_sym_ff;
                        res_err_in  = ERR_NONE;
                        state_in    = ST_OUT;
                     end else begin
                        state_in = ST_DRD;
                     end
                  end
                  OP_CLEAR: begin
                     present_in   = '0;
                     total_in     = '0;
                     root_in      = '0;
                     walk_in      = '0;
                     tree_ok_in   = 1'b0;
                     root_leaf_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end

         // leaf pass: one symbol slot per visit, read weight only if present
         ST_LRD: begin
            if (sidx_ff == SCNT_W'(SYMBOL_COUNT)) begin
               res_sym_in = '0;
               res_err_in = ERR_NONE;
               live_in    = total_ff;
               if (total_ff == '0) begin
                  tree_ok_in   = 1'b0;
                  root_leaf_in = 1'b0;
                  root_in      = '0;
                  walk_in      = '0;
                  res_kind_in  = KIND_ERROR;
                  res_err_in   = ERR_EMPTY;
                  state_in     = ST_OUT;
               end else if (total_ff == CNT_W'(1)) begin
                  tree_ok_in   = 1'b1;
                  root_leaf_in = 1'b1;
                  root_in      = '0;
                  walk_in      = '0;
                  res_kind_in  = KIND_BUILT;
                  state_in     = ST_OUT;
               end else begin
                  scan_in  = '0;
                  f1_in    = 1'b0;
                  f2_in    = 1'b0;
                  state_in = ST_SCAN;
               end
            end else if (present_ff[sidx_ff[SYM_W-1:0]]) begin
               state_in = ST_LWR;
            end else begin
               sidx_in = sidx_ff + SCNT_W'(1);
            end
         end

         ST_LWR: begin
            if (present_ff[sidx_ff[SYM_W-1:0]]) begin
               total_in    = total_ff + CNT_W'(1);
               root_sym_in = 8'(sidx_ff);
            end
            sidx_in  = sidx_ff + SCNT_W'(1);
            state_in = ST_LRD;
         end

         // one node read per cycle; keep the two lowest (weight, number) pairs
         ST_SCAN: begin
            if (scan_ff != total_ff) begin
               scan_in = scan_ff + CNT_W'(1);
               sv_in   = 1'b1;
            end
            if (sv_ff && node_rd[LIVE_OFF]) begin
               if (!f1_ff || cur_w < w1) begin
                  b2_in = b1_ff;
                  i2_in = i1_ff;
                  f2_in = f1_ff;
                  b1_in = node_rd;
                  i1_in = idx_d_ff;
                  f1_in = 1'b1;
               end else if (!f2_ff || cur_w < w2) begin
                  b2_in = node_rd;
                  i2_in = idx_d_ff;
                  f2_in = 1'b1;
               end
            end
            if (scan_ff == total_ff && !sv_ff) begin
               state_in = ST_KILLA;
            end
         end

         ST_KILLA: state_in = ST_KILLB;
         ST_KILLB: state_in = ST_MERGE;

         ST_MERGE: begin
            total_in = total_ff + CNT_W'(1);
            live_in  = live_ff - CNT_W'(1);
            if (live_ff - CNT_W'(1) > CNT_W'(1) &&
                total_ff + CNT_W'(1) < CNT_W'(NODE_DEPTH)) begin
               scan_in  = '0;
               f1_in    = 1'b0;
               f2_in    = 1'b0;
               state_in = ST_SCAN;
            end else begin
               tree_ok_in   = 1'b1;
               root_leaf_in = 1'b0;
               root_in      = total_ff[NI-1:0];
               walk_in      = total_ff[NI-1:0];
               res_kind_in  = KIND_BUILT;
               res_sym_in   = '0;
               res_err_in   = ERR_NONE;
               state_in     = ST_OUT;
            end
         end

         ST_DRD: state_in = ST_DNXT;

         ST_DNXT: begin
            nxt_in   = next_node;
            state_in = ST_DCHK;
         end

         // leaf test: a leaf points to itself on both sides
         ST_DCHK: begin
            if (node_rd[LEFT_OFF +: NI] == node_rd[RIGHT_OFF +: NI]) begin
               walk_in     = root_ff;
               res_kind_in = KIND_SYMBOL;
               res_sym_in  = node_rd[SYM_OFF +: SYM_OUT_W];
               res_err_in  = ERR_NONE;
               state_in    = ST_OUT;
            end else begin
               walk_in  = nxt_ff;
               state_in = ST_IDLE;
            end
         end

         // hold the result until the output register frees up
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_sym_in   = res_sym_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         present_ff   <= '0;
         total_ff     <= '0;
         live_ff      <= '0;
         scan_ff      <= '0;
         sidx_ff      <= '0;
         sv_ff        <= 1'b0;
         f1_ff        <= 1'b0;
         f2_ff        <= 1'b0;
         root_ff      <= '0;
         walk_ff      <= '0;
         tree_ok_ff   <= 1'b0;
         root_leaf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         total_ff     <= total_in;
         live_ff      <= live_in;
         scan_ff      <= scan_in;
         sidx_ff      <= sidx_in;
         sv_ff        <= sv_in;
         f1_ff        <= f1_in;
         f2_ff        <= f2_in;
         root_ff      <= root_in;
         walk_ff      <= walk_in;
         tree_ok_ff   <= tree_ok_in;
         root_leaf_ff <= root_leaf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_d_ff    <= idx_d_in;
      i1_ff       <= i1_in;
      i2_ff       <= i2_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      nxt_ff      <= nxt_in;
      root_sym_ff <= root_sym_in;
      bit_ff      <= bit_in;
      res_kind_ff <= res_kind_in;
      res_sym_ff  <= res_sym_in;
      res_err_ff  <= res_err_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign req_if.ready          = (state_ff == ST_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.result_kind    = rsp_kind_ff;
   assign rsp_if.decoded_symbol = rsp_sym_ff;
   assign rsp_if.error_code     = rsp_err_ff;

endmodule

### src/htbd_checker.sv
module htbd_checker
   import htbd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] result_kind,
   input logic [7:0] decoded_symbol,
   input logic [1:0] error_code
);

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (result_kind == KIND_BUILT || result_kind == KIND_SYMBOL ||
                     result_kind == KIND_ERROR))
      else $error("bad result kind");

   a_err_only_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && result_kind != KIND_ERROR) |-> error_code == ERR_NONE)
      else $error("error code without error kind");

   a_sym_only_on_symbol: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && result_kind != KIND_SYMBOL) |-> decoded_symbol == 8'd0)
      else $error("symbol without symbol kind");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(result_kind) &&
                                     $stable(decoded_symbol) && $stable(error_code)))
      else $error("stalled result changed");

endmodule

bind huffman_tree_build_and_decode_core htbd_checker u_htbd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .result_kind    (rsp_if.result_kind),
   .decoded_symbol (rsp_if.decoded_symbol),
   .error_code     (rsp_if.error_code)
);
